// ----- rtl/core/nfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg
// shared types and constants of the next-fit slot id allocator
// ----------------------------------------------------------------------------
package nfa_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ID_W      = 6;
	localparam int OP_W      = 2;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [ID_W-1:0]   id_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_CLAIM   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LOOKUP,
		ST_RESP
	} state_t;

	// one write port and one read port on the occupancy memory
	typedef struct packed {
		logic  we;
		slot_t waddr;
		logic  wdata;
		logic  re;
		slot_t raddr;
	} ram_req_t;

	localparam slot_t LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

endpackage

// ----- rtl/core/nfa_occ_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_occ_ram
// occupancy memory, one bit per slot, registered read data
// ----------------------------------------------------------------------------
module nfa_occ_ram (
	input  logic            clk,
	input  nfa_pkg::ram_req_t req,
	output logic            rd_data
);
	import nfa_pkg::*;

	logic mem [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

// ----- rtl/core/next_fit_slot_id_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slot_id_allocator_core
// next-fit slot id allocator: allocate, claim, release and query requests
// over an occupancy memory with a rotating search pointer
// ----------------------------------------------------------------------------
// claim, release and query: the result passes through the lookup and response states into the output register
// allocate: examines 1 .. NUM_SLOTS slots starting at the pointer, one memory read
// per cycle through the single read port sets the scan speed
// a new request is taken once the previous result sits in the output register,
// so requests never overlap and a stalled output holds back the next request
// reset: clearing pass with s_tready low frees every slot; pointer zero
module next_fit_slot_id_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nfa_pkg::IN_DATA_W-1:0] s_tdata,  // [5:0] slot_id, [7:6] zero
	input  logic [nfa_pkg::OP_W-1:0]      s_tuser,  // [1:0] operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nfa_pkg::OUT_DATA_W-1:0] m_tdata  // [5:0] result_id, [6] status,
	                                                // [7] was_occupied
);
	import nfa_pkg::*;

	state_t   state_q, state_d;
	op_t      op_q;
	id_t      sid_q;
	logic     in_table_q;
	slot_t    ptr_q;
	slot_t    chk_q;
	slot_t    tested_q;
	slot_t    next_chk;
	id_t      res_id_q, res_id_d;
	logic     res_st_q, res_st_d;
	logic     res_occ_q, res_occ_d;
	logic     res_load;
	logic     out_load;
	logic     out_valid_q;
	id_t      out_id_q;
	logic     out_st_q;
	logic     out_occ_q;
	ram_req_t ram_req;
	logic     rd_data;
	op_t      op_in;
	id_t      sid_in;
	logic     in_table_in;
	logic     accept;

	assign op_in       = op_t'(s_tuser);
	assign sid_in      = s_tdata[ID_W-1:0];
	assign in_table_in = (32'(sid_in) < 32'(NUM_SLOTS));
	assign accept      = s_tvalid && s_tready;
	assign next_chk    = (chk_q == LAST_SLOT) ? '0 : chk_q + SLOT_W'(1);

	nfa_occ_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (chk_q == LAST_SLOT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = (op_in == OP_ALLOC) ? ST_SCAN : ST_LOOKUP;
			end
			ST_SCAN: begin
				if (!rd_data || tested_q == LAST_SLOT) state_d = ST_RESP;
			end
			ST_LOOKUP: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and memory control
	always_comb begin
		ram_req   = '0;
		s_tready  = 1'b0;
		res_load  = 1'b0;
		res_id_d  = '0;
		res_st_d  = 1'b0;
		res_occ_d = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = chk_q;
				ram_req.wdata = 1'b0;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = (op_in == OP_ALLOC) ? ptr_q : SLOT_W'(sid_in);
				end
			end
			ST_SCAN: begin
				if (!rd_data) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = chk_q;
					ram_req.wdata = 1'b1;
					res_load      = 1'b1;
					res_id_d      = ID_W'(chk_q);
				end else if (tested_q == LAST_SLOT) begin
					// every slot held: table full
					res_load = 1'b1;
					res_st_d = 1'b1;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = next_chk;
				end
			end
			ST_LOOKUP: begin
				res_load      = 1'b1;
				res_id_d      = sid_q;
				res_occ_d     = in_table_q && rd_data;
				ram_req.waddr = SLOT_W'(sid_q);
				if (in_table_q && op_q == OP_CLAIM) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = 1'b1;
				end else if (in_table_q && op_q == OP_RELEASE) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = 1'b0;
				end
			end
			ST_RESP: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			chk_q       <= '0;
			tested_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				chk_q <= next_chk;
			end
			if (accept && op_in == OP_ALLOC) begin
				chk_q    <= ptr_q;
				tested_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				if (!rd_data) begin
					ptr_q <= chk_q;
				end else if (tested_q != LAST_SLOT) begin
					chk_q    <= next_chk;
					tested_q <= tested_q + SLOT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			sid_q      <= sid_in;
			in_table_q <= in_table_in;
		end
		if (res_load) begin
			res_id_q  <= res_id_d;
			res_st_q  <= res_st_d;
			res_occ_q <= res_occ_d;
		end
		if (out_load) begin
			out_id_q  <= res_id_q;
			out_st_q  <= res_st_q;
			out_occ_q <= res_occ_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_occ_q, out_st_q, out_id_q};

	// the scan only takes a slot whose stored bit read back free
	a_scan_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ram_req.we) |-> (!rd_data && ram_req.wdata))
		else $error("scan wrote a slot that was not free");

	// a full result only ever comes from an allocate request
	a_full_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_st_d) |-> (op_q == OP_ALLOC))
		else $error("full status on a non-allocate request");

	// no request is taken during the clearing pass
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("request taken during clearing pass");

	// an allocate request starts its scan at the pointer
	a_alloc_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_in == OP_ALLOC) |=> (state_q == ST_SCAN && chk_q == $past(ptr_q)))
		else $error("allocate did not start scan at the pointer");

endmodule
